// ===== rtl/core/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies.
package wsd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // one request queued from the parser to the output stage
   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] key_byte;
      logic       byte_valid;
      logic [3:0] opcode;
      logic       fin;
      logic       frame_end;
   } rec_type;

endpackage

// ===== rtl/core/wsd_front.sv =====
// Frame parser: header, extended length and mask key tracking; classifies bytes.
// Depends on wsd_pkg.
module wsd_front import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   output logic       push,
   output rec_type    push_rec
);

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_MASK    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] rem_ff, rem_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  pos_ff, pos_in;
   logic        len_done;
   logic        hdr_done;
   logic [7:0]  key_sel;

   always_comb begin
      unique case (pos_ff)
         2'd0: key_sel = key_ff[31:24];
         2'd1: key_sel = key_ff[23:16];
         2'd2: key_sel = key_ff[15:8];
         2'd3: key_sel = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      push      = 1'b0;
      push_rec  = '{data_byte: 8'd0, key_byte: 8'd0, byte_valid: 1'b0,
                    opcode: opcode_ff, fin: fin_ff, frame_end: 1'b1};
      if (accept) begin
         unique case (phase_ff)
            PH_HDR1: begin
               mask_in = data_byte[7];
               rem_in  = 64'd0;
               if (data_byte[6:0] == LEN_EXT16) begin
                  cnt_in   = 3'd6;
                  phase_in = PH_EXTLEN;
               end else if (data_byte[6:0] == LEN_EXT64) begin
                  cnt_in   = 3'd0;
                  phase_in = PH_EXTLEN;
               end else begin
                  rem_in   = {57'd0, data_byte[6:0]};
                  len_done = 1'b1;
               end
            end
            PH_EXTLEN: begin
               rem_in = {rem_ff[55:0], data_byte};
               if (cnt_ff == 3'd7) begin
                  cnt_in   = 3'd0;
                  len_done = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], data_byte};
               if (cnt_ff >= 3'd3) begin
                  cnt_in   = 3'd0;
                  hdr_done = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_PAYLOAD: begin
               pos_in = pos_ff + 2'd1;
               rem_in = rem_ff - 64'd1;
               push   = 1'b1;
               push_rec.data_byte  = data_byte;
               push_rec.key_byte   = mask_ff ? key_sel : 8'd0;
               push_rec.byte_valid = 1'b1;
               push_rec.frame_end  = (rem_ff == 64'd1);
               if (rem_ff == 64'd1) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               fin_in    = data_byte[7];
               opcode_in = data_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase
      end
      if (len_done) begin
         key_in = 32'd0;
         if (mask_in) begin
            cnt_in   = 3'd0;
            phase_in = PH_MASK;
         end else begin
            hdr_done = 1'b1;
         end
      end
      if (hdr_done) begin
         pos_in = 2'd0;
         if (rem_in == 64'd0) begin
            phase_in = PH_HDR0;
            push     = 1'b1;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         fin_ff    <= 1'b0;
         opcode_ff <= 4'd0;
         mask_ff   <= 1'b0;
         rem_ff    <= 64'd0;
         cnt_ff    <= 3'd0;
         key_ff    <= 32'd0;
         pos_ff    <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         rem_ff    <= rem_in;
         cnt_ff    <= cnt_in;
         key_ff    <= key_in;
         pos_ff    <= pos_in;
      end
   end

   a_end_returns_hdr0: assert property (@(posedge clock) disable iff (reset)
      push && push_rec.frame_end |=> phase_ff == PH_HDR0)
      else $error("frame end without return to first header byte");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> rem_ff != 64'd0)
      else $error("payload phase with nothing left");

endmodule

// ===== rtl/core/wsd_queue.sv =====
// Short request queue between parser and output stage.
// Depends on wsd_pkg.
module wsd_queue import wsd_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output logic    not_empty,
   output logic    full,
   output rec_type pop_rec
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   rec_type            store_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;

   assign not_empty = (cnt_ff != CntW'(0));
   assign full      = (cnt_ff == CntW'(Depth));
   assign pop_rec   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? PtrW'(0) : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? PtrW'(0) : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with pointers apart");

endmodule

// ===== rtl/core/wsd_back.sv =====
// Output stage: unmasks queued requests into the result register.
// Depends on wsd_pkg.
module wsd_back import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  rec_type    q_rec,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_valid,
   output logic [3:0] rsp_opcode,
   output logic       rsp_fin,
   output logic       rsp_frame_end
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       bvalid_ff;
   logic [3:0] opcode_ff;
   logic       fin_ff;
   logic       end_ff;

   assign q_pop    = q_valid && (!valid_ff || !rsp_stall);
   assign valid_in = q_pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         byte_ff   <= q_rec.data_byte ^ q_rec.key_byte;
         bvalid_ff <= q_rec.byte_valid;
         opcode_ff <= q_rec.opcode;
         fin_ff    <= q_rec.fin;
         end_ff    <= q_rec.frame_end;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_byte_valid   = bvalid_ff;
   assign rsp_opcode       = opcode_ff;
   assign rsp_fin          = fin_ff;
   assign rsp_frame_end    = end_ff;

   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !bvalid_ff |-> end_ff && byte_ff == 8'd0)
      else $error("empty result not marked as frame end");

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: parser, request queue, output stage.
// Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.

// Accepts one stream byte per cycle while req_stall is low and returns one
// result per payload byte (one empty result for a zero-length frame); header,
// length and key bytes return nothing. Each result is registered first in the
// request queue and then in the output register. The parser runs at one byte
// per cycle; req_stall rises only when the request queue (QueueDepth entries)
// is full because rsp_stall has held results back.
module websocket_frame_deframer import wsd_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_valid,
   output logic [3:0] rsp_opcode,
   output logic       rsp_fin,
   output logic       rsp_frame_end
);

   logic    accept;
   logic    push;
   rec_type push_rec;
   logic    pop;
   logic    not_empty;
   logic    full;
   rec_type pop_rec;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   wsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .push      (push),
      .push_rec  (push_rec)
   );

   wsd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (pop),
      .not_empty (not_empty),
      .full      (full),
      .pop_rec   (pop_rec)
   );

   wsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (not_empty),
      .q_rec            (pop_rec),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_opcode       (rsp_opcode),
      .rsp_fin          (rsp_fin),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule
